FILE: design/cosag_pkg.sv
// shared types and constants for the center-out spiral address generator
package cosag_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int SIDE_W      = 7;
    localparam int COORD_W     = 6;
    localparam int SEQ_W       = 13;
    localparam int HEAD_W      = 2;
    localparam int LEGCNT_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_SIZE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_DIRECTION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_SENSE      = 2'd2;

    // headings
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd3;

    localparam logic [SIDE_W-1:0] GRID_SIZE_RESET = 7'd4;
    localparam logic [SIDE_W-1:0] SIDE_MAX        = SIDE_W'(MAX_SIDE);
    localparam logic [LEGCNT_W-1:0] LEGS_SAT      = 2'd3;
    localparam logic [LEGCNT_W-1:0] LEGS_GROW     = 2'd2;

    typedef struct packed {
        logic [SIDE_W-1:0] grid_size;
        logic [HEAD_W-1:0] start_direction;
        logic              turn_sense;
    } cosag_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  column;
        logic [HEAD_W-1:0]   heading;
        logic [COORD_W-1:0]  leg_length;
        logic [COORD_W-1:0]  steps_in_leg;
        logic [LEGCNT_W-1:0] legs_at_length;
        logic [SEQ_W-1:0]    cells_emitted;
        logic                running;
    } cosag_state_t;

endpackage

FILE: design/cosag_step.sv
// next walk state and final-cell flag for one tick of the spiral
module cosag_step
    import cosag_pkg::*;
(
    input  cosag_cfg_t   cfg,
    input  cosag_state_t cur,
    input  logic         restart,
    output cosag_state_t nxt,
    output logic         last
);

    logic [SIDE_W-1:0]    side;
    logic [COORD_W-1:0]   side_m1;
    logic [COORD_W-1:0]   half;
    logic [2*SIDE_W-1:0]  side_sq;
    logic [SEQ_W-1:0]     total;
    logic                 even;
    logic                 off_both;
    logic                 off_col;
    logic                 off_row;
    logic [COORD_W-1:0]   leg_len;
    logic [LEGCNT_W-1:0]  legs;
    logic [COORD_W-1:0]   steps;

    always_comb
    begin
        // clamp the side length into 1..MAX_SIDE
        if (cfg.grid_size == '0)
        begin
            side = SIDE_W'(1);
        end
        else if (cfg.grid_size > SIDE_MAX)
        begin
            side = SIDE_MAX;
        end
        else
        begin
            side = cfg.grid_size;
        end
        side_m1 = COORD_W'(side - SIDE_W'(1));
        half    = side[SIDE_W-1:1];
        side_sq = side * side;
        total   = side_sq[SEQ_W-1:0];
        even    = ~side[0];

        // even grids move the start cell so the first leg stays inside
        off_both = (cfg.start_direction == HEAD_RIGHT && !cfg.turn_sense) ||
                   (cfg.start_direction == HEAD_DOWN  &&  cfg.turn_sense);
        off_col  = (cfg.start_direction == HEAD_RIGHT &&  cfg.turn_sense) ||
                   (cfg.start_direction == HEAD_UP    && !cfg.turn_sense);
        off_row  = (cfg.start_direction == HEAD_DOWN  && !cfg.turn_sense) ||
                   (cfg.start_direction == HEAD_LEFT  &&  cfg.turn_sense);

        nxt     = cur;
        leg_len = cur.leg_length;
        legs    = cur.legs_at_length;
        steps   = cur.steps_in_leg;

        if (restart || !cur.running)
        begin
            nxt.row            = half - COORD_W'(even && (off_both || off_row));
            nxt.column         = half - COORD_W'(even && (off_both || off_col));
            nxt.heading        = cfg.start_direction;
            nxt.leg_length     = COORD_W'(1);
            nxt.steps_in_leg   = '0;
            nxt.legs_at_length = '0;
            nxt.cells_emitted  = SEQ_W'(1);
        end
        else
        begin
            if (cur.steps_in_leg == '0 && cur.leg_length < side_m1 &&
                cur.legs_at_length >= LEGS_GROW)
            begin
                leg_len = cur.leg_length + COORD_W'(1);
                legs    = '0;
            end
            unique case (cur.heading)
                HEAD_RIGHT: nxt.column = cur.column + COORD_W'(1);
                HEAD_DOWN:  nxt.row    = cur.row + COORD_W'(1);
                HEAD_LEFT:  nxt.column = cur.column - COORD_W'(1);
                HEAD_UP:    nxt.row    = cur.row - COORD_W'(1);
                default:    nxt.row    = cur.row;
            endcase
            steps = cur.steps_in_leg + COORD_W'(1);
            if (steps >= leg_len)
            begin
                nxt.heading = cfg.turn_sense ? cur.heading - HEAD_W'(1)
                                             : cur.heading + HEAD_W'(1);
                if (legs < LEGS_SAT)
                begin
                    legs = legs + LEGCNT_W'(1);
                end
                steps = '0;
            end
            nxt.leg_length     = leg_len;
            nxt.legs_at_length = legs;
            nxt.steps_in_leg   = steps;
            nxt.cells_emitted  = cur.cells_emitted + SEQ_W'(1);
        end

        last        = nxt.cells_emitted >= total;
        nxt.running = ~last;
    end

endmodule

FILE: design/center_out_spiral_address_generator_top.sv
// top level of the center-out spiral address generator
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata[0] restart
//  m_*       out        m_tvalid/m_tready  m_tdata row, column, sequence; m_tlast final cell
//  cfg_*     in         cfg_we             cfg_index selects register, cfg_data value
//
// one word in, one word out; a word accepted at an edge shows on m_* after that edge
// sustained rate is one word per cycle with m_tready high, set by the single output register
// s_tready stays high while the output register is empty or being taken
// reset puts the walk out of run, so the first word starts a spiral at the center
// configuration reset: grid size 4, start heading right, turning clockwise
module center_out_spiral_address_generator_top
    import cosag_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [0] restart, [7:1] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [5:0] row_index, [11:6] column_index,
                                              // [24:12] sequence_number, [31:25] zero
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cosag_cfg_t   cfg_reg;
    cosag_state_t state_reg;
    cosag_state_t state_next;
    logic         last_next;
    logic         in_accept;

    logic                 out_valid_reg;
    logic [COORD_W-1:0]   out_row_reg;
    logic [COORD_W-1:0]   out_column_reg;
    logic [SEQ_W-1:0]     out_seq_reg;
    logic                 out_last_reg;

    assign s_tready  = ~out_valid_reg | m_tready;
    assign in_accept = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_size       <= GRID_SIZE_RESET;
            cfg_reg.start_direction <= HEAD_RIGHT;
            cfg_reg.turn_sense      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_SIZE:       cfg_reg.grid_size       <= cfg_data;
                CFG_START_DIRECTION: cfg_reg.start_direction <= cfg_data[HEAD_W-1:0];
                CFG_TURN_SENSE:      cfg_reg.turn_sense      <= cfg_data[0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    cosag_step u_step (
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .restart (s_tdata[0]),
        .nxt     (state_next),
        .last    (last_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.row            <= '0;
            state_reg.column         <= '0;
            state_reg.heading        <= HEAD_RIGHT;
            state_reg.leg_length     <= COORD_W'(1);
            state_reg.steps_in_leg   <= '0;
            state_reg.legs_at_length <= '0;
            state_reg.cells_emitted  <= '0;
            state_reg.running        <= 1'b0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_row_reg    <= state_next.row;
            out_column_reg <= state_next.column;
            out_seq_reg    <= state_next.cells_emitted;
            out_last_reg   <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - SEQ_W - 2*COORD_W)'(0), out_seq_reg,
                       out_column_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

    a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_tvalid)
        else $error("accepted word did not reach the output register");

    a_restart_seq_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_tdata[0] |=> out_seq_reg == SEQ_W'(1))
        else $error("restart did not begin a new spiral");

    a_last_stops_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && last_next |=> !state_reg.running)
        else $error("walk still running after the final cell");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while the output word is stalled");

    a_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_seq_reg != '0)
        else $error("output word with sequence number zero");

endmodule
